// ===== rtl/assert_macros.svh =====
// Assertion macros used by the allocator core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked during reset
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, masked during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/bma_pkg.sv =====
// ----------------------------------------------------------------------------
// Bitmap allocator package
// Word geometry, operation and status codes, and the word unit result type.
// ----------------------------------------------------------------------------
package bma_pkg;

  localparam int WORD_W          = 8;
  localparam int BIT_W           = 3;
  localparam int DEF_MAX_ENTRIES = 256;

  localparam logic [1:0] OP_ALLOCATE = 2'd0;
  localparam logic [1:0] OP_SET      = 2'd1;
  localparam logic [1:0] OP_QUERY    = 2'd2;
  localparam logic [1:0] OP_COUNT    = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic             hit;   // a free active bit exists in the word
    logic [BIT_W-1:0] pos;   // lowest free active bit
    logic [BIT_W:0]   ones;  // used active bits in the word
  } word_res_t;

endpackage

// ===== rtl/bma_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bma_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/bma_word_unit.sv =====
// ----------------------------------------------------------------------------
// Bitmap word unit
// Masks one bitmap word to the active entries, finds its lowest free bit and
// counts its used bits.
// ----------------------------------------------------------------------------
module bma_word_unit #(
  parameter int WAW = 5,
  parameter int NW  = 9
) (
  input  logic [bma_pkg::WORD_W-1:0] word,
  input  logic [WAW-1:0]             widx,
  input  logic [NW-1:0]              active,
  output bma_pkg::word_res_t         res
);
  import bma_pkg::*;

  localparam int CMPW = ((WAW + BIT_W) > NW) ? (WAW + BIT_W) : NW;

  logic [WORD_W-1:0] valid;
  logic [WORD_W-1:0] free_bits;
  logic [WORD_W-1:0] used_bits;

  always_comb begin
    for (int b = 0; b < WORD_W; b++) begin
      valid[b] = CMPW'({widx, BIT_W'(b)}) < CMPW'(active);
    end
    free_bits = valid & ~word;
    used_bits = valid & word;
  end

  always_comb begin
    res.hit  = |free_bits;
    res.pos  = '0;
    res.ones = '0;
    // scan from the top so the lowest free bit wins
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (free_bits[b]) begin
        res.pos = BIT_W'(b);
      end
    end
    for (int b = 0; b < WORD_W; b++) begin
      res.ones = res.ones + (BIT_W + 1)'(used_bits[b]);
    end
  end

endmodule

// ===== rtl/inode_bitmap_allocator_core.sv =====
// ----------------------------------------------------------------------------
// Inode bitmap allocator core
// First-fit used/free bitmap with allocate, set, query and count operations.
// ----------------------------------------------------------------------------
// The bitmap lives in a RAM of 8-bit words and is worked on one word per cycle
// by a single word unit. After reset the block runs a clearing pass over all
// ceil(MAX_ENTRIES/8) words before it takes its first word. Set and query go
// through read, modify/write and result steps, straight to the result when the
// index is out of range. Allocate and count scan the words holding the
// active entries, reading one RAM word per cycle; allocate stops at the first
// word holding a free entry, and with no active entries both go straight to
// the result. One operation is in progress at a time; a finished result sits
// in the output register while the next word is accepted, and the block waits
// in its last step for as long as that register is still held.
module inode_bitmap_allocator_core #(
  parameter int MAX_ENTRIES = bma_pkg::DEF_MAX_ENTRIES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [8:0]  cfg_wr_data,   // entries_in_use
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,       // operation[1:0], entry_index[9:2], flag_value[10]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata        // found_index[7:0], used_flag[8], used_count[17:9],
                                     // status[19:18]
);
  import bma_pkg::*;

  localparam int DEPTH = (MAX_ENTRIES + WORD_W - 1) / WORD_W;
  localparam int WAW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW    = $clog2(MAX_ENTRIES + 1);
  localparam int XW    = (NW > 9) ? NW : 9;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_RD    = 3'd2;
  localparam logic [2:0] S_RMW   = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  logic [2:0]       state;
  logic [8:0]       entries_in_use;
  logic [1:0]       req_op;
  logic [7:0]       req_idx;
  logic             req_val;
  logic [WAW:0]     ptr;
  logic             pend;
  logic [WAW-1:0]   pend_word;
  logic [NW-1:0]    acc;
  logic [7:0]       res_found;
  logic             res_flag;
  logic [8:0]       res_count;
  logic [1:0]       res_status;

  logic [1:0]       in_op;
  logic [7:0]       in_idx;
  logic             in_val;
  logic             in_range;
  logic [XW-1:0]    cfg_x;
  logic [XW-1:0]    max_x;
  logic [NW-1:0]    active;
  logic [NW:0]      nw_sum;
  logic [WAW:0]     nwords;
  logic [WAW:0]     last_word_w;
  logic [WAW-1:0]   last_word;
  logic [WAW-1:0]   req_word;
  logic [BIT_W-1:0] req_bit;
  logic             issue;
  logic [XW-1:0]    gidx_x;
  logic [NW-1:0]    acc_sum;
  logic [XW-1:0]    acc_x;

  logic             ram_we;
  logic [WAW-1:0]   ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [WAW-1:0]   ram_raddr;
  logic [WORD_W-1:0] ram_rdata;
  word_res_t        wres;

  assign in_op  = s_tdata[1:0];
  assign in_idx = s_tdata[9:2];
  assign in_val = s_tdata[10];

  // active count saturates at the bitmap size
  assign cfg_x  = XW'(entries_in_use);
  assign max_x  = XW'(MAX_ENTRIES);
  assign active = (cfg_x > max_x) ? NW'(max_x) : NW'(cfg_x);

  assign in_range    = XW'(in_idx) < XW'(active);
  assign nw_sum      = {1'b0, active} + (NW + 1)'(WORD_W - 1);
  assign nwords      = (WAW + 1)'(nw_sum >> BIT_W);
  assign last_word_w = nwords - (WAW + 1)'(1);
  assign last_word   = last_word_w[WAW-1:0];
  assign req_word    = WAW'(XW'(req_idx) >> BIT_W);
  assign req_bit     = req_idx[BIT_W-1:0];
  assign issue       = (state == S_SCAN) && (ptr < nwords);
  assign gidx_x      = XW'({pend_word, wres.pos});
  assign acc_sum     = acc + NW'(wres.ones);
  assign acc_x       = XW'(acc_sum);

  assign s_tready = (state == S_IDLE);

  bma_word_unit #(
    .WAW (WAW),
    .NW  (NW)
  ) u_word (
    .word   (ram_rdata),
    .widx   (pend_word),
    .active (active),
    .res    (wres)
  );

  bma_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH),
    .AW    (WAW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ptr[WAW-1:0];
    ram_wdata = '0;
    ram_raddr = (state == S_SCAN) ? ptr[WAW-1:0] : req_word;
    unique case (state)
      S_CLEAR: begin
        ram_we = 1'b1;
      end
      S_RMW: begin
        ram_waddr = req_word;
        ram_wdata = (ram_rdata & ~(WORD_W'(1) << req_bit)) |
                    (WORD_W'(req_val) << req_bit);
        ram_we    = (req_op == OP_SET);
      end
      S_SCAN: begin
        ram_waddr = pend_word;
        ram_wdata = ram_rdata | (WORD_W'(1) << wres.pos);
        ram_we    = pend && (req_op == OP_ALLOCATE) && wres.hit;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entries_in_use <= 9'd256;
    end else if (cfg_wr_en) begin
      entries_in_use <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      ptr      <= '0;
      pend     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (state == S_FIN && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          ptr <= ptr + (WAW + 1)'(1);
          if (ptr == (WAW + 1)'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            req_op     <= in_op;
            req_idx    <= in_idx;
            req_val    <= in_val;
            res_found  <= '0;
            res_flag   <= 1'b0;
            res_count  <= '0;
            res_status <= ST_OK;
            ptr        <= '0;
            pend       <= 1'b0;
            acc        <= '0;
            priority case (1'b1)
              (in_op == OP_SET || in_op == OP_QUERY) && !in_range: begin
                res_flag   <= (in_op == OP_QUERY);
                res_status <= ST_RANGE;
                state      <= S_FIN;
              end
              (in_op == OP_SET || in_op == OP_QUERY): begin
                state <= S_RD;
              end
              (active == '0): begin
                res_status <= (in_op == OP_ALLOCATE) ? ST_FULL : ST_OK;
                state      <= S_FIN;
              end
              default: begin
                state <= S_SCAN;
              end
            endcase
          end
        end
        S_RD: begin
          state <= S_RMW;
        end
        S_RMW: begin
          if (req_op == OP_QUERY) begin
            res_flag <= ram_rdata[req_bit];
          end
          state <= S_FIN;
        end
        S_SCAN: begin
          // read one word ahead while the previous one is evaluated
          if (issue) begin
            ptr <= ptr + (WAW + 1)'(1);
          end
          pend      <= issue;
          pend_word <= ptr[WAW-1:0];
          if (pend) begin
            if (req_op == OP_ALLOCATE) begin
              if (wres.hit) begin
                res_found <= gidx_x[7:0];
                state     <= S_FIN;
              end else if (pend_word == last_word) begin
                res_status <= ST_FULL;
                state      <= S_FIN;
              end
            end else begin
              acc <= acc_sum;
              if (pend_word == last_word) begin
                res_count <= acc_x[8:0];
                state     <= S_FIN;
              end
            end
          end
        end
        S_FIN: begin
          // hold until the output register is free
          if (!m_tvalid || m_tready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && (!m_tvalid || m_tready)) begin
      m_tdata <= {4'd0, res_status, res_count, res_flag, res_found};
    end
  end

`include "assert_macros.svh"

  `ASSERT_NEXT(a_busy_after_accept, clk, rst, s_tvalid && s_tready, !s_tready)
  `ASSERT_IMPL(a_pend_in_range, clk, rst, (state == S_SCAN) && pend, {1'b0, pend_word} < nwords)
  `ASSERT_IMPL(a_full_no_index, clk, rst, m_tvalid && (m_tdata[19:18] == ST_FULL), m_tdata[7:0] == 8'd0)

endmodule
